/* hw/rtl/asp_pkg.sv */
// Shared types, constants and codes of the array stack block.
package asp_pkg;

  // Sizes
  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int MODE_W = 3;
  localparam int STAT_W = 3;
  localparam int LOC_W  = 6;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (LOC_W > CNT_W) ? LOC_W : CNT_W;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UPDATE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DISPLAY = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADLOC    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND  = 3'd4;

  // Word returned on errors
  localparam logic signed [DATA_W-1:0] ERR_WORD = '1;

  // Read address select
  localparam logic [1:0] RD_TOP  = 2'd0;  // count - 1
  localparam logic [1:0] RD_LOC  = 2'd1;  // peek location
  localparam logic [1:0] RD_PREV = 2'd2;  // pointer - 1

  // Result data source
  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_ERR  = 2'd1;
  localparam logic [1:0] SRC_RAM  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic              item_ld;
    logic              push;
    logic              pop;
    logic              upd_wr;
    logic              rd_en;
    logic [1:0]        rd_sel;
    logic              emit;
    logic [1:0]        emit_src;
    logic [STAT_W-1:0] emit_status;
    logic              emit_last;
  } asp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              loc_bad;
    logic              match;
    logic              ptr_zero;
    logic              slot_free;
  } asp_sts_t;

endpackage

/* hw/rtl/asp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module asp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/asp_dp.sv */
// Datapath: item registers, stack count, entry RAM, walk pointer, result register.
module asp_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [asp_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [asp_pkg::DATA_W-1:0] in_value,
  input  logic signed [asp_pkg::DATA_W-1:0] in_new_value,
  input  logic [asp_pkg::LOC_W-1:0]         in_location,
  input  asp_pkg::asp_cmd_t                 cmd,
  output asp_pkg::asp_sts_t                 sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [asp_pkg::DATA_W-1:0] out_data,
  output logic [asp_pkg::STAT_W-1:0]        out_status,
  output logic                              out_last
);

  // Latched transaction
  logic [asp_pkg::MODE_W-1:0]        mode_r;
  logic signed [asp_pkg::DATA_W-1:0] value_r;
  logic signed [asp_pkg::DATA_W-1:0] new_value_r;
  logic [asp_pkg::LOC_W-1:0]         location_r;

  logic [asp_pkg::CNT_W-1:0]  count_r, count_nxt, cnt_dec;
  logic [asp_pkg::ADDR_W-1:0] ptr_r;
  logic [asp_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic [asp_pkg::DATA_W-1:0] wr_data, rd_data;
  logic                       wr_en;

  logic                              out_valid_r, out_valid_nxt;
  logic signed [asp_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic [asp_pkg::STAT_W-1:0]        out_status_r;
  logic                              out_last_r;

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      mode_r      <= in_mode;
      value_r     <= in_value;
      new_value_r <= in_new_value;
      location_r  <= in_location;
    end
  end

  // Stack count
  assign cnt_dec = count_r - asp_pkg::CNT_W'(1);

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + asp_pkg::CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Read address select; the pointer follows every read
  always_comb begin
    unique case (cmd.rd_sel)
      asp_pkg::RD_TOP:  rd_addr = cnt_dec[asp_pkg::ADDR_W-1:0];
      asp_pkg::RD_LOC:  rd_addr = location_r[asp_pkg::ADDR_W-1:0];
      asp_pkg::RD_PREV: rd_addr = ptr_r - asp_pkg::ADDR_W'(1);
      default:          rd_addr = ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      ptr_r <= rd_addr;
    end
  end

  // Write port: push at the top, update at the pointer
  assign wr_en   = cmd.push | cmd.upd_wr;
  assign wr_addr = cmd.push ? count_r[asp_pkg::ADDR_W-1:0] : ptr_r;
  assign wr_data = cmd.push ? value_r : new_value_r;

  asp_ram #(
    .WIDTH (asp_pkg::DATA_W),
    .DEPTH (asp_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Status to controller
  assign sts.mode      = mode_r;
  assign sts.full      = (count_r == asp_pkg::CNT_W'(asp_pkg::DEPTH));
  assign sts.empty     = (count_r == '0);
  assign sts.loc_bad   = (asp_pkg::CMP_W'(location_r) >= asp_pkg::CMP_W'(count_r));
  assign sts.match     = (rd_data == value_r);
  assign sts.ptr_zero  = (ptr_r == '0);
  assign sts.slot_free = !out_valid_r || out_ready;

  // Result register
  always_comb begin
    unique case (cmd.emit_src)
      asp_pkg::SRC_ZERO: out_data_nxt = '0;
      asp_pkg::SRC_RAM:  out_data_nxt = rd_data;
      default:           out_data_nxt = asp_pkg::ERR_WORD;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= cmd.emit_status;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

/* hw/rtl/asp_ctrl.sv */
// Controller: state machine that sequences each transaction over the datapath.
module asp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  asp_pkg::asp_sts_t sts,
  output asp_pkg::asp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RDOUT = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_DISP  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_ld = 1'b1;
          state_nxt   = S_EXEC;
        end
      end

      S_EXEC: begin
        cmd.emit_last = 1'b1;
        if (sts.mode == asp_pkg::MODE_PUSH) begin
          if (sts.slot_free) begin
            cmd.emit = 1'b1;
            state_nxt = S_IDLE;
            if (sts.full) begin
              cmd.emit_src    = asp_pkg::SRC_ERR;
              cmd.emit_status = asp_pkg::ST_OVERFLOW;
            end else begin
              cmd.push        = 1'b1;
              cmd.emit_src    = asp_pkg::SRC_ZERO;
              cmd.emit_status = asp_pkg::ST_OK;
            end
          end
        end else if (sts.mode != asp_pkg::MODE_POP && sts.mode != asp_pkg::MODE_PEEK &&
                     sts.mode != asp_pkg::MODE_UPDATE && sts.mode != asp_pkg::MODE_DISPLAY) begin
          // meaningless mode: dropped
          state_nxt = S_IDLE;
        end else if (sts.empty) begin
          if (sts.slot_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_src    = asp_pkg::SRC_ERR;
            cmd.emit_status = asp_pkg::ST_UNDERFLOW;
            state_nxt       = S_IDLE;
          end
        end else if (sts.mode == asp_pkg::MODE_POP) begin
          cmd.pop    = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = asp_pkg::RD_TOP;
          state_nxt  = S_RDOUT;
        end else if (sts.mode == asp_pkg::MODE_PEEK) begin
          if (sts.loc_bad) begin
            if (sts.slot_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_src    = asp_pkg::SRC_ERR;
              cmd.emit_status = asp_pkg::ST_BADLOC;
              state_nxt       = S_IDLE;
            end
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = asp_pkg::RD_LOC;
            state_nxt  = S_RDOUT;
          end
        end else begin
          // update or display: start from the top entry
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = asp_pkg::RD_TOP;
          state_nxt  = (sts.mode == asp_pkg::MODE_UPDATE) ? S_SRCH : S_DISP;
        end
      end

      S_RDOUT: begin
        if (sts.slot_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_src    = asp_pkg::SRC_RAM;
          cmd.emit_status = asp_pkg::ST_OK;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      // Walk down from the top, one entry a cycle
      S_SRCH: begin
        cmd.emit_last = 1'b1;
        if (sts.match) begin
          if (sts.slot_free) begin
            cmd.upd_wr      = 1'b1;
            cmd.emit        = 1'b1;
            cmd.emit_src    = asp_pkg::SRC_ZERO;
            cmd.emit_status = asp_pkg::ST_OK;
            state_nxt       = S_IDLE;
          end
        end else if (sts.ptr_zero) begin
          if (sts.slot_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_src    = asp_pkg::SRC_ERR;
            cmd.emit_status = asp_pkg::ST_NOTFOUND;
            state_nxt       = S_IDLE;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = asp_pkg::RD_PREV;
        end
      end

      // One result per entry, top first; holds while the output is stalled
      S_DISP: begin
        if (sts.slot_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_src    = asp_pkg::SRC_RAM;
          cmd.emit_status = asp_pkg::ST_OK;
          cmd.emit_last   = sts.ptr_zero;
          if (sts.ptr_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = asp_pkg::RD_PREV;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/array_stack_peek_update.sv */
// Top level of the array stack: controller plus datapath.
//
// Bounded LIFO of signed 32-bit words (asp_pkg::DEPTH entries) in a RAM.
// Input channel (in_valid/in_ready) carries one command transaction: push,
// pop, peek at a bottom-based location, update by value, or display all.
// Result channel (out_valid/out_ready) carries data, status and last; last
// marks the final result of a command.
// Push, and the overflow, underflow and bad-location errors, load their result
// from the execute state; pop and peek read the RAM and load the entry from
// the read-out state. Update searches one entry per cycle from the top through
// the RAM's single read port and stops at the topmost match or at the bottom
// entry. Display loads one result per entry, top first, one per cycle while the
// output is not stalled. A new command is taken the cycle after the previous
// one has loaded its last result, so it may be accepted while that result
// still waits; commands with invalid modes are dropped without a result.
// While a result waits with out_ready low, the output register holds and the
// sequencer waits before loading another result.
// Reset (rst_n, synchronous) empties the stack and clears out_valid; the
// RAM contents are not cleared and need no clearing pass.
module array_stack_peek_update (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [asp_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [asp_pkg::DATA_W-1:0] in_value,
  input  logic signed [asp_pkg::DATA_W-1:0] in_new_value,
  input  logic [asp_pkg::LOC_W-1:0]         in_location,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [asp_pkg::DATA_W-1:0] out_data,
  output logic [asp_pkg::STAT_W-1:0]        out_status,
  output logic                              out_last
);

  asp_pkg::asp_cmd_t cmd;
  asp_pkg::asp_sts_t sts;

  // Sequencer
  asp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and result path
  asp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mode      (in_mode),
    .in_value     (in_value),
    .in_new_value (in_new_value),
    .in_location  (in_location),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_last     (out_last)
  );

endmodule

/* hw/rtl/asp_chk.sv */
// Port-level checker for the array stack, bound to the top level.
module asp_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [asp_pkg::MODE_W-1:0]        in_mode,
  input logic signed [asp_pkg::DATA_W-1:0] in_value,
  input logic signed [asp_pkg::DATA_W-1:0] in_new_value,
  input logic [asp_pkg::LOC_W-1:0]         in_location,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [asp_pkg::DATA_W-1:0] out_data,
  input logic [asp_pkg::STAT_W-1:0]        out_status,
  input logic                              out_last
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) &&
    $stable(out_status) && $stable(out_last))
    else $error("stalled result changed");

  // Errors end their command
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != asp_pkg::ST_OK |-> out_last)
    else $error("error result without last");

  // Errors carry the error word
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != asp_pkg::ST_OK |-> out_data == asp_pkg::ERR_WORD)
    else $error("error result with wrong data");

  // Only display streams several results, all ok
  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == asp_pkg::ST_OK)
    else $error("non-final result with error status");

  // One command at a time: ready drops after each transaction
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

endmodule

bind array_stack_peek_update asp_chk u_asp_chk (.*);

/* dv/tb_top.sv */
// Self-checking testbench for the array stack: directed, full-stack, backpressure and random runs.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = asp_pkg::DEPTH + 40;

  // One expected result transaction
  typedef struct packed {
    logic signed [asp_pkg::DATA_W-1:0] data;
    logic [asp_pkg::STAT_W-1:0]        status;
    logic                              last;
  } stack_rsp_t;

  // Clock, reset and DUT ports
  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [asp_pkg::MODE_W-1:0]        in_mode = '0;
  logic signed [asp_pkg::DATA_W-1:0] in_value = '0;
  logic signed [asp_pkg::DATA_W-1:0] in_new_value = '0;
  logic [asp_pkg::LOC_W-1:0]         in_location = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [asp_pkg::DATA_W-1:0] out_data;
  logic [asp_pkg::STAT_W-1:0]        out_status;
  logic                              out_last;

  // Shadow stack state
  logic signed [asp_pkg::DATA_W-1:0] stk_mem [asp_pkg::DEPTH];
  int                                stk_count = 0;
  int                                stk_peak = 0;
  stack_rsp_t                        stack_rsp_q [$];
  stack_rsp_t                        exp_rsp;

  // Traffic control and bookkeeping
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit tx_live = 1'b0;
  int rx_hold = 0;
  int cycle_cnt = 0;
  int err_cnt = 0;
  int results_seen = 0;
  int mode_cnt [8];
  int stat_cnt [8];

  array_stack_peek_update i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_value     (in_value),
    .in_new_value (in_new_value),
    .in_location  (in_location),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_cnt,
               stack_rsp_q.size());
      $display("array_stack_peek_update: mismatch");
      $finish;
    end
  end

  function automatic void flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic stack_rsp_t mk_rsp(input logic signed [asp_pkg::DATA_W-1:0] data,
                                        input logic [asp_pkg::STAT_W-1:0] status,
                                        input logic last);
    stack_rsp_t r;
    r.data   = data;
    r.status = status;
    r.last   = last;
    return r;
  endfunction

  // Random word biased toward extremes and small values (duplicates for update)
  function automatic logic signed [asp_pkg::DATA_W-1:0] rand_word();
    logic signed [asp_pkg::DATA_W-1:0] w;
    case ($urandom_range(0, 7))
      0:       w = {1'b0, {(asp_pkg::DATA_W-1){1'b1}}};
      1:       w = {1'b1, {(asp_pkg::DATA_W-1){1'b0}}};
      2:       w = '1;
      3:       w = '0;
      4, 5:    w = $urandom_range(0, 8) - 4;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Apply one accepted command to the shadow stack and queue its results
  task automatic stack_apply(input logic [asp_pkg::MODE_W-1:0] mode,
                             input logic signed [asp_pkg::DATA_W-1:0] value,
                             input logic signed [asp_pkg::DATA_W-1:0] new_value,
                             input logic [asp_pkg::LOC_W-1:0] location);
    int idx;
    bit hit;
    hit = 1'b0;
    mode_cnt[mode]++;
    if (mode == asp_pkg::MODE_PUSH) begin
      if (stk_count >= asp_pkg::DEPTH) begin
        stack_rsp_q.push_back(mk_rsp(asp_pkg::ERR_WORD, asp_pkg::ST_OVERFLOW, 1'b1));
      end else begin
        stk_mem[stk_count] = value;
        stk_count++;
        stack_rsp_q.push_back(mk_rsp('0, asp_pkg::ST_OK, 1'b1));
      end
    end else if (mode > asp_pkg::MODE_DISPLAY) begin
      // meaningless mode: dropped, no result
    end else if (stk_count == 0) begin
      stack_rsp_q.push_back(mk_rsp(asp_pkg::ERR_WORD, asp_pkg::ST_UNDERFLOW, 1'b1));
    end else begin
      case (mode)
        asp_pkg::MODE_POP: begin
          stk_count--;
          stack_rsp_q.push_back(mk_rsp(stk_mem[stk_count], asp_pkg::ST_OK, 1'b1));
        end
        asp_pkg::MODE_PEEK: begin
          if (location >= stk_count)
            stack_rsp_q.push_back(mk_rsp(asp_pkg::ERR_WORD, asp_pkg::ST_BADLOC, 1'b1));
          else
            stack_rsp_q.push_back(mk_rsp(stk_mem[location], asp_pkg::ST_OK, 1'b1));
        end
        asp_pkg::MODE_UPDATE: begin
          // topmost match wins
          for (idx = stk_count - 1; idx >= 0; idx--) begin
            if (!hit && stk_mem[idx] == value) begin
              stk_mem[idx] = new_value;
              hit = 1'b1;
            end
          end
          if (hit)
            stack_rsp_q.push_back(mk_rsp('0, asp_pkg::ST_OK, 1'b1));
          else
            stack_rsp_q.push_back(mk_rsp(asp_pkg::ERR_WORD, asp_pkg::ST_NOTFOUND, 1'b1));
        end
        default: begin
          // display: top first, last flag on the bottom entry
          for (idx = stk_count - 1; idx >= 0; idx--)
            stack_rsp_q.push_back(mk_rsp(stk_mem[idx], asp_pkg::ST_OK, idx == 0));
        end
      endcase
    end
    if (stk_count > stk_peak) stk_peak = stk_count;
  endtask

  // Offer one command transaction and wait for it to be taken
  task automatic issue_cmd(input logic [asp_pkg::MODE_W-1:0] mode,
                           input logic signed [asp_pkg::DATA_W-1:0] value,
                           input logic signed [asp_pkg::DATA_W-1:0] new_value,
                           input logic [asp_pkg::LOC_W-1:0] location);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      if (tx_live) in_valid <= 1'b0;
      tx_live = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_value     <= value;
    in_new_value <= new_value;
    in_location  <= location;
    do @(posedge clk); while (!in_ready);
    tx_live = 1'b1;
    stack_apply(mode, value, new_value, location);
  endtask

  // Stop offering and wait until every owed result has come back
  task automatic await_stack_idle();
    if (tx_live) in_valid <= 1'b0;
    tx_live = 1'b0;
    while (stack_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Result receiver: random stalls, plus long hold-offs on request
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      gap = rx_idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready) && rx_hold == 0);
    end
  end

  // Result checker: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (stack_rsp_q.size() == 0) begin
        flag_error($sformatf("unexpected result: data %0d status %0d last %0d",
                             out_data, out_status, out_last));
      end else begin
        exp_rsp = stack_rsp_q.pop_front();
        stat_cnt[exp_rsp.status]++;
        if (out_data !== exp_rsp.data)
          flag_error($sformatf("data: expected %0d, got %0d", exp_rsp.data, out_data));
        if (out_status !== exp_rsp.status)
          flag_error($sformatf("status: expected %0d, got %0d", exp_rsp.status, out_status));
        if (out_last !== exp_rsp.last)
          flag_error($sformatf("last: expected %0d, got %0d", exp_rsp.last, out_last));
      end
    end
  end

  // Every non-push action on an empty stack
  task automatic test_empty_stack();
    issue_cmd(asp_pkg::MODE_POP, rand_word(), rand_word(), '0);
    issue_cmd(asp_pkg::MODE_PEEK, rand_word(), rand_word(), '0);
    issue_cmd(asp_pkg::MODE_UPDATE, '0, rand_word(), '1);
    issue_cmd(asp_pkg::MODE_DISPLAY, rand_word(), rand_word(), '1);
  endtask

  // Push extremes, peek in and out of range, pop
  task automatic test_push_pop_peek();
    issue_cmd(asp_pkg::MODE_PUSH, {1'b0, {(asp_pkg::DATA_W-1){1'b1}}}, '0, '0);
    issue_cmd(asp_pkg::MODE_PUSH, {1'b1, {(asp_pkg::DATA_W-1){1'b0}}}, '1, '1);
    issue_cmd(asp_pkg::MODE_PUSH, '1, '0, '0);
    issue_cmd(asp_pkg::MODE_PUSH, '0, '1, '1);
    issue_cmd(asp_pkg::MODE_PEEK, '0, '0, 6'd0);
    issue_cmd(asp_pkg::MODE_PEEK, '1, '1, 6'd3);
    issue_cmd(asp_pkg::MODE_PEEK, '0, '0, 6'd4);
    issue_cmd(asp_pkg::MODE_PEEK, '0, '0, '1);
    issue_cmd(asp_pkg::MODE_POP, '1, '1, '1);
  endtask

  // Update hits the topmost duplicate, misses, then display and a further update that hits
  task automatic test_update_display();
    issue_cmd(asp_pkg::MODE_PUSH, {1'b0, {(asp_pkg::DATA_W-1){1'b1}}}, '0, '0);
    issue_cmd(asp_pkg::MODE_UPDATE, {1'b0, {(asp_pkg::DATA_W-1){1'b1}}}, 32'sd5, '0);
    issue_cmd(asp_pkg::MODE_UPDATE, 32'sd1234, 32'sd9, '0);
    issue_cmd(asp_pkg::MODE_DISPLAY, '0, '0, '0);
    issue_cmd(asp_pkg::MODE_UPDATE, '1, {1'b1, {(asp_pkg::DATA_W-1){1'b0}}}, '1);
  endtask

  // Undefined modes are dropped without a result; a peek follows
  task automatic test_ignored_modes();
    issue_cmd(3'd5, '1, '1, '1);
    issue_cmd(3'd6, rand_word(), rand_word(), '0);
    issue_cmd(3'd7, '0, '0, '1);
    issue_cmd(asp_pkg::MODE_PEEK, '0, '0, 6'd3);
  endtask

  // Fill to DEPTH, overflow, top peek, full display and search, then drain past empty
  task automatic test_full_stack();
    while (stk_count < asp_pkg::DEPTH)
      issue_cmd(asp_pkg::MODE_PUSH, rand_word(), rand_word(),
                asp_pkg::LOC_W'($urandom_range(0, 63)));
    issue_cmd(asp_pkg::MODE_PUSH, rand_word(), rand_word(), '0);
    issue_cmd(asp_pkg::MODE_PUSH, rand_word(), rand_word(), '1);
    issue_cmd(asp_pkg::MODE_PEEK, rand_word(), rand_word(),
              asp_pkg::LOC_W'(asp_pkg::DEPTH - 1));
    issue_cmd(asp_pkg::MODE_DISPLAY, rand_word(), rand_word(), '0);
    issue_cmd(asp_pkg::MODE_UPDATE, stk_mem[0], rand_word(), '0);
    while (stk_count > 0)
      issue_cmd(asp_pkg::MODE_POP, rand_word(), rand_word(),
                asp_pkg::LOC_W'($urandom_range(0, 63)));
    issue_cmd(asp_pkg::MODE_POP, rand_word(), rand_word(), '0);
  endtask

  // Receiver holds off while the sender keeps sending display and peek commands in
  task automatic test_backpressure();
    int k;
    tx_idle_on = 1'b0;
    while (stk_count < 12) issue_cmd(asp_pkg::MODE_PUSH, rand_word(), rand_word(), '0);
    await_stack_idle();
    rx_hold = 250;
    for (k = 0; k < 8; k++) begin
      if (k % 2 == 0)
        issue_cmd(asp_pkg::MODE_DISPLAY, rand_word(), rand_word(), '0);
      else
        issue_cmd(asp_pkg::MODE_PEEK, rand_word(), rand_word(),
                  asp_pkg::LOC_W'($urandom_range(0, 15)));
    end
    await_stack_idle();
    tx_idle_on = 1'b1;
  endtask

  // One random command; mostly well formed, some undefined modes
  task automatic random_cmd(input int push_pct, output bit counted);
    int r;
    logic [asp_pkg::MODE_W-1:0] mode;
    logic signed [asp_pkg::DATA_W-1:0] value;
    logic signed [asp_pkg::DATA_W-1:0] new_value;
    logic [asp_pkg::LOC_W-1:0] loc;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      mode = asp_pkg::MODE_W'($urandom_range(5, 7));
    end else if (r < 4 + push_pct) begin
      mode = asp_pkg::MODE_PUSH;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 35)      mode = asp_pkg::MODE_POP;
      else if (r < 65) mode = asp_pkg::MODE_PEEK;
      else if (r < 90) mode = asp_pkg::MODE_UPDATE;
      else             mode = asp_pkg::MODE_DISPLAY;
    end
    value     = rand_word();
    new_value = rand_word();
    loc       = asp_pkg::LOC_W'($urandom_range(0, 63));
    // aim searches and peeks at live entries most of the time
    if (stk_count > 0 && $urandom_range(0, 3) != 0) begin
      if (mode == asp_pkg::MODE_UPDATE) value = stk_mem[$urandom_range(0, stk_count - 1)];
      if (mode == asp_pkg::MODE_PEEK)   loc = asp_pkg::LOC_W'($urandom_range(0, stk_count - 1));
    end
    issue_cmd(mode, value, new_value, loc);
    counted = (mode <= asp_pkg::MODE_DISPLAY);
  endtask

  // Random phases with different push bias and idle patterns
  task automatic test_random();
    int phase;
    int n;
    int push_pct;
    bit counted;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       push_pct = 60;
        1:       push_pct = 40;
        2:       push_pct = 85;
        3:       push_pct = 15;
        default: push_pct = 35;
      endcase
      tx_idle_on = (phase == 1) ? 1'b0 : (phase == 4) ? 1'b1 : bit'($urandom_range(0, 1));
      rx_idle_on = (phase == 1) ? 1'b0 : (phase == 4) ? 1'b1 : bit'($urandom_range(0, 1));
      n = 0;
      while (n < 16) begin
        random_cmd(push_pct, counted);
        if (counted) n++;
      end
    end
  endtask

  // Test sequence
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_stack();
    test_push_pop_peek();
    test_update_display();
    test_ignored_modes();
    test_full_stack();
    test_backpressure();
    test_random();

    await_stack_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (stack_rsp_q.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", stack_rsp_q.size()));

    $display("commands: push %0d, pop %0d, peek %0d, update %0d, display %0d, dropped %0d",
             mode_cnt[asp_pkg::MODE_PUSH], mode_cnt[asp_pkg::MODE_POP],
             mode_cnt[asp_pkg::MODE_PEEK], mode_cnt[asp_pkg::MODE_UPDATE],
             mode_cnt[asp_pkg::MODE_DISPLAY], mode_cnt[5] + mode_cnt[6] + mode_cnt[7]);
    $display({"results: %0d checked, overflow %0d, underflow %0d, bad loc %0d, ",
              "not found %0d, peak depth %0d, %0d errors"},
             results_seen, stat_cnt[asp_pkg::ST_OVERFLOW], stat_cnt[asp_pkg::ST_UNDERFLOW],
             stat_cnt[asp_pkg::ST_BADLOC], stat_cnt[asp_pkg::ST_NOTFOUND], stk_peak,
             err_cnt);
    if (err_cnt == 0) begin
      $display("array_stack_peek_update: match");
    end else begin
      $display("array_stack_peek_update: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/asp_pkg.sv
hw/rtl/asp_ram.sv
hw/rtl/asp_dp.sv
hw/rtl/asp_ctrl.sv
hw/rtl/array_stack_peek_update.sv
hw/rtl/asp_chk.sv
dv/tb_top.sv
